@@ design/rchc_pkg.sv @@
// Shared types and constants for the red cluster HSV classifier core.
package rchc_pkg;

    // Quotient width of the shared divider; every quotient it produces fits here
    localparam int QUO_W = 17;

    // Configuration register indexes
    localparam logic [1:0] CFG_HUE_LOW  = 2'd0;
    localparam logic [1:0] CFG_HUE_HIGH = 2'd1;
    localparam logic [1:0] CFG_SAT_MIN  = 2'd2;
    localparam logic [1:0] CFG_VAL_MIN  = 2'd3;

    // Register reset values
    localparam logic [15:0] HUE_LOW_RESET  = 16'd5243;
    localparam logic [15:0] HUE_HIGH_RESET = 16'd60293;
    localparam logic [16:0] SAT_MIN_RESET  = 17'd13107;
    localparam logic [15:0] VAL_MIN_RESET  = 16'd6553;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_HDIV,
        S_SDIV,
        S_ACC,
        S_MHDIV,
        S_MSDIV,
        S_MVDIV,
        S_DONE
    } t_state;

endpackage

@@ design/red_cluster_hsv_classifier_core.sv @@
// Red cluster HSV classifier: per-point HSV, per-cluster means and red test.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------------------
//  input    | in        | i_in_valid / o_in_stall   | i_red i_green i_blue i_cluster_end
//           |           |                           | i_scene_end
//  output   | out       | o_out_valid / i_out_stall | o_cluster_number .. o_count_overflow
//  config   | in        | i_cfg_we                  | i_cfg_index i_cfg_data
//
//  One restoring divider, one quotient bit a cycle, does all division; each division is one
//  load followed by QUO_W = 17 restoring steps. A coloured point runs the hue and
//  saturation divisions, a grey point skips both and a point past the count limit is not summed.
//  A closing point adds three mean divisions and a finish state that waits for the
//  output word register to free. Reset is synchronous and active low; a stalled output word
//  holds while the next point is already taken in.
module red_cluster_hsv_classifier_core #(
    parameter int MAX_POINTS   = 65536,
    parameter int MAX_CLUSTERS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_cluster_end,
    input  logic        i_scene_end,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_cluster_number,
    output logic [15:0] o_mean_hue,
    output logic [16:0] o_mean_sat,
    output logic [15:0] o_mean_val,
    output logic        o_is_red,
    output logic [9:0]  o_target_cluster,
    output logic        o_scene_done,
    output logic        o_count_overflow
);

    localparam int QW  = rchc_pkg::QUO_W;
    localparam int PW  = $clog2(MAX_POINTS + 1);
    localparam int CW  = (MAX_CLUSTERS > 2) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int HTW = 16 + PW;
    localparam int STW = 17 + PW;
    localparam int VTW = 16 + PW;
    localparam int DW  = (STW > 27) ? STW : 27;
    localparam int VW  = (PW > 11) ? PW : 11;
    localparam int SW  = $clog2(QW + 1);

    // configuration registers
    logic [15:0] r_hue_low, r_hue_high, r_val_min;
    logic [16:0] r_sat_min;

    // sequencer and point latch
    rchc_pkg::t_state r_state, n_state;
    logic [7:0]  r_red, r_green, r_blue;
    logic        r_cend, r_send;

    // per-point and per-cluster results
    logic [15:0] r_h;
    logic [16:0] r_s;
    logic [15:0] r_mh, r_mv;
    logic [16:0] r_ms;
    logic [HTW-1:0] r_htot;
    logic [STW-1:0] r_stot;
    logic [VTW-1:0] r_vtot;
    logic [PW-1:0]  r_tally;
    logic           r_drop;
    logic [CW-1:0]  r_cnt, r_target;

    // shared divider
    logic [VW-1:0] r_rem, r_div;
    logic [QW-1:0] r_dsh, r_quo;
    logic [SW-1:0] r_step;

    // output word register
    logic        r_out_valid;
    logic [9:0]  r_o_num, r_o_target;
    logic [15:0] r_o_mh, r_o_mv;
    logic [16:0] r_o_ms;
    logic        r_o_red, r_o_scene, r_o_ovf;

    // control
    logic in_accept, out_free, div_state, div_load, div_done;
    logic tally_full;

    // colour arithmetic
    logic [7:0]  mx, mn, delta;
    logic [10:0] d6, num;
    logic [15:0] vv;

    // divider datapath
    logic [DW-1:0]    div_dividend;
    logic [VW-1:0]    div_divisor;
    logic [DW-QW-1:0] ld_hi;
    logic [VW:0]      rem_sh, rem_diff;
    logic             ge;
    logic [QW-1:0]    quo_next;

    // red test and cluster number widening
    logic           is_red;
    logic [CW+9:0]  cnt_wide, tgt_wide;
    logic [CW-1:0]  tgt_next;

    // Work out max, min, delta and the hexcone hue numerator
    always_comb begin
        mx = (r_red > r_green) ? r_red : r_green;
        mn = (r_red < r_green) ? r_red : r_green;
        mx = (mx > r_blue) ? mx : r_blue;
        mn = (mn < r_blue) ? mn : r_blue;
        delta = mx - mn;
        d6 = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
        if (mx == r_red) begin
            num = {3'b000, r_green} - {3'b000, r_blue};
            if (r_green < r_blue) begin
                num = num + d6;
            end
        end else if (mx == r_green) begin
            num = {2'b00, delta, 1'b0} + {3'b000, r_blue} - {3'b000, r_red};
        end else begin
            num = {1'b0, delta, 2'b00} + {3'b000, r_red} - {3'b000, r_green};
        end
        vv = {mx, mx};
    end

    // Select the divider operands for the current division
    always_comb begin
        unique case (r_state)
            rchc_pkg::S_SDIV: begin
                div_dividend = DW'({delta, 16'h0000});
                div_divisor  = VW'(mx);
            end
            rchc_pkg::S_MHDIV: begin
                div_dividend = DW'(r_htot);
                div_divisor  = VW'(r_tally);
            end
            rchc_pkg::S_MSDIV: begin
                div_dividend = DW'(r_stot);
                div_divisor  = VW'(r_tally);
            end
            rchc_pkg::S_MVDIV: begin
                div_dividend = DW'(r_vtot);
                div_divisor  = VW'(r_tally);
            end
            default: begin
                div_dividend = DW'({num, 16'h0000});
                div_divisor  = VW'(d6);
            end
        endcase
        ld_hi = div_dividend[DW-1:QW];
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh   = {r_rem, r_dsh[QW-1]};
        rem_diff = rem_sh - {1'b0, r_div};
        ge       = (rem_sh >= {1'b0, r_div});
        quo_next = {r_quo[QW-2:0], ge};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rchc_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (!tally_full) begin
                        n_state = rchc_pkg::S_HDIV;
                    end else if (i_cluster_end) begin
                        n_state = rchc_pkg::S_MHDIV;
                    end
                end
            end
            rchc_pkg::S_HDIV: begin
                if (div_load && delta == 8'd0) begin
                    n_state = rchc_pkg::S_ACC;
                end else if (div_done) begin
                    n_state = rchc_pkg::S_SDIV;
                end
            end
            rchc_pkg::S_SDIV: begin
                if (div_done) begin
                    n_state = rchc_pkg::S_ACC;
                end
            end
            rchc_pkg::S_ACC: begin
                n_state = r_cend ? rchc_pkg::S_MHDIV : rchc_pkg::S_IDLE;
            end
            rchc_pkg::S_MHDIV: begin
                if (div_done) begin
                    n_state = rchc_pkg::S_MSDIV;
                end
            end
            rchc_pkg::S_MSDIV: begin
                if (div_done) begin
                    n_state = rchc_pkg::S_MVDIV;
                end
            end
            rchc_pkg::S_MVDIV: begin
                if (div_done) begin
                    n_state = rchc_pkg::S_DONE;
                end
            end
            rchc_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = rchc_pkg::S_IDLE;
                end
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        div_state  = 1'b0;
        unique case (r_state)
            rchc_pkg::S_IDLE:  o_in_stall = 1'b0;
            rchc_pkg::S_HDIV,
            rchc_pkg::S_SDIV,
            rchc_pkg::S_MHDIV,
            rchc_pkg::S_MSDIV,
            rchc_pkg::S_MVDIV: div_state = 1'b1;
            rchc_pkg::S_ACC,
            rchc_pkg::S_DONE:  div_state = 1'b0;
        endcase
        in_accept = i_in_valid && !o_in_stall;
        out_free  = !r_out_valid || !i_out_stall;
        div_load  = div_state && (r_step == SW'(0));
        div_done  = div_state && (r_step == SW'(QW));
        tally_full = (r_tally == PW'(MAX_POINTS));
    end

    // Red test on the means, widen the cluster numbers to the port width
    always_comb begin
        is_red = (r_mh < r_hue_low || r_mh >= r_hue_high) &&
                 (r_ms > r_sat_min) && (r_mv > r_val_min);
        tgt_next = is_red ? r_cnt : r_target;
        cnt_wide = {10'd0, r_cnt};
        tgt_wide = {10'd0, tgt_next};
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low  <= rchc_pkg::HUE_LOW_RESET;
            r_hue_high <= rchc_pkg::HUE_HIGH_RESET;
            r_sat_min  <= rchc_pkg::SAT_MIN_RESET;
            r_val_min  <= rchc_pkg::VAL_MIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rchc_pkg::CFG_HUE_LOW:  r_hue_low  <= i_cfg_data[15:0];
                rchc_pkg::CFG_HUE_HIGH: r_hue_high <= i_cfg_data[15:0];
                rchc_pkg::CFG_SAT_MIN:  r_sat_min  <= i_cfg_data;
                rchc_pkg::CFG_VAL_MIN:  r_val_min  <= i_cfg_data[15:0];
            endcase
        end
    end

    // Advance the sequencer and the divider step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rchc_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (div_state && n_state == r_state && !div_done) begin
                r_step <= r_step + SW'(1);
            end else begin
                r_step <= '0;
            end
        end
    end

    // Latch the accepted word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_cend  <= i_cluster_end;
            r_send  <= i_scene_end;
        end
    end

    // Shared divider: load, then one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (div_load) begin
            r_rem <= VW'(ld_hi);
            r_dsh <= div_dividend[QW-1:0];
            r_div <= div_divisor;
            r_quo <= '0;
        end else if (div_state) begin
            r_rem <= ge ? rem_diff[VW-1:0] : rem_sh[VW-1:0];
            r_dsh <= {r_dsh[QW-2:0], 1'b0};
            r_quo <= quo_next;
        end
    end

    // Capture quotients
    always_ff @(posedge i_clk) begin
        if (r_state == rchc_pkg::S_HDIV && div_load && delta == 8'd0) begin
            r_h <= '0;
            r_s <= '0;
        end
        if (div_done) begin
            unique case (r_state)
                rchc_pkg::S_HDIV:  r_h  <= quo_next[15:0];
                rchc_pkg::S_SDIV:  r_s  <= quo_next;
                rchc_pkg::S_MHDIV: r_mh <= quo_next[15:0];
                rchc_pkg::S_MSDIV: r_ms <= quo_next;
                rchc_pkg::S_MVDIV: r_mv <= quo_next[15:0];
                default: ;
            endcase
        end
    end

    // Cluster sums, point count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_htot  <= '0;
            r_stot  <= '0;
            r_vtot  <= '0;
            r_tally <= '0;
            r_drop  <= 1'b0;
        end else if (r_state == rchc_pkg::S_DONE && out_free) begin
            r_htot  <= '0;
            r_stot  <= '0;
            r_vtot  <= '0;
            r_tally <= '0;
            r_drop  <= 1'b0;
        end else if (r_state == rchc_pkg::S_ACC) begin
            r_htot  <= r_htot + HTW'(r_h);
            r_stot  <= r_stot + STW'(r_s);
            r_vtot  <= r_vtot + VTW'(vv);
            r_tally <= r_tally + PW'(1);
        end else if (in_accept && tally_full) begin
            r_drop  <= 1'b1;
        end
    end

    // Cluster counter and target; drop both at the end of a scene
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_target <= '0;
        end else if (r_state == rchc_pkg::S_DONE && out_free) begin
            if (r_send) begin
                r_cnt    <= '0;
                r_target <= '0;
            end else begin
                r_target <= tgt_next;
                if (r_cnt == CW'(MAX_CLUSTERS - 1)) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
        end
    end

    // Output word register: load when free, drop the valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == rchc_pkg::S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rchc_pkg::S_DONE && out_free) begin
            r_o_num    <= cnt_wide[9:0];
            r_o_mh     <= r_mh;
            r_o_ms     <= r_ms;
            r_o_mv     <= r_mv;
            r_o_red    <= is_red;
            r_o_target <= tgt_wide[9:0];
            r_o_scene  <= r_send;
            r_o_ovf    <= r_drop;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_cluster_number = r_o_num;
    assign o_mean_hue       = r_o_mh;
    assign o_mean_sat       = r_o_ms;
    assign o_mean_val       = r_o_mv;
    assign o_is_red         = r_o_red;
    assign o_target_cluster = r_o_target;
    assign o_scene_done     = r_o_scene;
    assign o_count_overflow = r_o_ovf;

endmodule
